// ===== hdl/fgq_pkg.sv =====
package fgq_pkg;

   localparam int unsigned ID_W     = 6;
   localparam int unsigned TALLY_W  = 9;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned CNT_W    = 7;
   localparam int unsigned RESULT_CAP = 64;

   // request kinds
   localparam logic [FUNC_W-1:0] FUNC_ADD      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_INFLUENT = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_ACTIVE   = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MUTUAL   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_SUGGEST  = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   // outcome of the shared compare unit
   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_res_type;

endpackage

// ===== hdl/follower_graph_query_engine_core.sv =====
// channel   | ports                      | payload
// ----------+----------------------------+--------------------------------------
// request   | req_tvalid/tready/tdata/   | tdata: first_id, second_id
//           | tuser                      | tuser: func
// response  | rsp_tvalid/tready/tdata/   | tdata: user_id, tally, status
//           | tlast                      | tlast: last
// csr       | csr_valid/ready/data       | user_count
//
// one request at a time under a sequencer; every table access goes through a
// memory with a registered read, so each lookup has an address state and a data state
// reset needs no clearing pass: length and activity tables carry valid bits
// a stalled response holds the sequencer at its next result
module follower_graph_query_engine_core #(
   parameter int unsigned MAX_USERS  = 63,
   parameter int unsigned MAX_DEGREE = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // first_id [5:0], second_id [11:6], zero pad
   input  logic [2:0]  req_tuser,   // func [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // user_id [5:0], tally [14:6], status [16:15]
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [5:0]  csr_data
);
   import fgq_pkg::*;

   // ids are six bits, so tables never need more than 64 rows
   localparam int unsigned LIVE_CAP_I = (MAX_USERS < 63) ? MAX_USERS : 63;
   localparam int unsigned USER_DEPTH = LIVE_CAP_I + 1;
   localparam int unsigned UW         = $clog2(USER_DEPTH);
   localparam int unsigned DW         = $clog2(MAX_DEGREE + 1);
   localparam int unsigned ST_DEPTH   = USER_DEPTH * MAX_DEGREE;
   localparam int unsigned SAW        = $clog2(ST_DEPTH);
   localparam logic [6:0]  LIVE_CAP   = 7'(LIVE_CAP_I);

   typedef enum logic [20:0] {
      S_IDLE     = 21'(1) << 0,
      S_CHK      = 21'(1) << 1,
      S_ADD_RD   = 21'(1) << 2,
      S_ADD_WR   = 21'(1) << 3,
      S_SCAN_RD  = 21'(1) << 4,
      S_SCAN_CMP = 21'(1) << 5,
      S_MUT_LA   = 21'(1) << 6,
      S_MUT_LB   = 21'(1) << 7,
      S_MUT_LBW  = 21'(1) << 8,
      S_MUT_F1   = 21'(1) << 9,
      S_MUT_F1W  = 21'(1) << 10,
      S_MUT_F2   = 21'(1) << 11,
      S_MUT_F2W  = 21'(1) << 12,
      S_SUG_LA   = 21'(1) << 13,
      S_SUG_LAW  = 21'(1) << 14,
      S_SUG_MID  = 21'(1) << 15,
      S_SUG_MIDW = 21'(1) << 16,
      S_SUG_LM   = 21'(1) << 17,
      S_SUG_F    = 21'(1) << 18,
      S_SUG_FW   = 21'(1) << 19,
      S_FIN      = 21'(1) << 20
   } state_type;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [ID_W-1:0]     a_ff, a_in, b_ff, b_in;
   logic [ID_W-1:0]     user_count_ff;
   logic [DW-1:0]       i_ff, i_in, j_ff, j_in;
   logic [DW-1:0]       len_a_ff, len_a_in, len_b_ff, len_b_in;
   logic [ID_W-1:0]     f1_ff, f1_in, mid_ff, mid_in;
   logic [6:0]          u_ff, u_in;
   logic [TALLY_W-1:0]  best_ff, best_in;
   logic [ID_W-1:0]     best_id_ff, best_id_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic                hold_vld_ff, hold_vld_in;
   logic [ID_W-1:0]     hold_id_ff, hold_id_in;
   logic [TALLY_W-1:0]  hold_tally_ff, hold_tally_in;
   logic [STATUS_W-1:0] hold_status_ff, hold_status_in;
   logic [USER_DEPTH-1:0] seen_ff, seen_in;
   logic [USER_DEPTH-1:0] len_vld_ff, len_vld_in, act_vld_ff, act_vld_in;
   logic [UW-1:0]       len_raddr_ff, act_raddr_ff;

   // output register
   logic                rsp_valid_ff;
   logic [23:0]         rsp_data_ff;
   logic                rsp_last_ff;

   // memory ports
   logic               st_we;
   logic [SAW-1:0]     st_waddr, st_raddr;
   logic [ID_W-1:0]    st_wdata, st_q;
   logic               len_we;
   logic [UW-1:0]      len_waddr, len_raddr;
   logic [DW-1:0]      len_wdata, len_q, len_rd;
   logic               act_we;
   logic [UW-1:0]      act_waddr, act_raddr;
   logic [TALLY_W-1:0] act_wdata, act_q, act_rd;

   // shared compare unit
   logic [8:0]  cmp_x, cmp_y;
   cmp_res_type cmp_res;

   // result emission
   logic                out_free;
   logic                emit_go;
   logic [ID_W-1:0]     emit_id;
   logic [TALLY_W-1:0]  emit_tally;
   logic [STATUS_W-1:0] emit_status;
   logic                emit_last;

   logic [6:0] live;
   logic       a_ok, b_ok, found;

   function automatic logic [SAW-1:0] st_addr(input logic [ID_W-1:0] id,
                                              input logic [DW-1:0] k);
      st_addr = SAW'(SAW'(id[UW-1:0]) * SAW'(MAX_DEGREE)) + SAW'(k);
   endfunction

   fgq_ram #(.WIDTH(ID_W), .DEPTH(ST_DEPTH)) u_store (
      .clock(clock), .wr_en(st_we), .wr_addr(st_waddr), .wr_data(st_wdata),
      .rd_addr(st_raddr), .rd_data(st_q)
   );

   fgq_ram #(.WIDTH(DW), .DEPTH(USER_DEPTH)) u_len (
      .clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
      .rd_addr(len_raddr), .rd_data(len_q)
   );

   fgq_ram #(.WIDTH(TALLY_W), .DEPTH(USER_DEPTH)) u_act (
      .clock(clock), .wr_en(act_we), .wr_addr(act_waddr), .wr_data(act_wdata),
      .rd_addr(act_raddr), .rd_data(act_q)
   );

   fgq_cmp u_cmp (.op_x(cmp_x), .op_y(cmp_y), .res(cmp_res));

   // a row never written reads as zero
   assign len_rd = len_vld_ff[len_raddr_ff] ? len_q : '0;
   assign act_rd = act_vld_ff[act_raddr_ff] ? act_q : '0;

   // effective user count, capped at the table size
   assign live = ({1'b0, user_count_ff} > LIVE_CAP) ? LIVE_CAP : {1'b0, user_count_ff};
   assign a_ok = (a_ff != '0) && ({1'b0, a_ff} <= live);
   assign b_ok = (b_ff != '0) && ({1'b0, b_ff} <= live);

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in       = state_ff;
      func_in        = func_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      i_in           = i_ff;
      j_in           = j_ff;
      len_a_in       = len_a_ff;
      len_b_in       = len_b_ff;
      f1_in          = f1_ff;
      mid_in         = mid_ff;
      u_in           = u_ff;
      best_in        = best_ff;
      best_id_in     = best_id_ff;
      n_in           = n_ff;
      hold_vld_in    = hold_vld_ff;
      hold_id_in     = hold_id_ff;
      hold_tally_in  = hold_tally_ff;
      hold_status_in = hold_status_ff;
      seen_in        = seen_ff;
      len_vld_in     = len_vld_ff;
      act_vld_in     = act_vld_ff;
      st_we          = 1'b0;
      st_waddr       = '0;
      st_wdata       = '0;
      st_raddr       = '0;
      len_we         = 1'b0;
      len_waddr      = '0;
      len_wdata      = '0;
      len_raddr      = '0;
      act_we         = 1'b0;
      act_waddr      = '0;
      act_wdata      = '0;
      act_raddr      = '0;
      cmp_x          = '0;
      cmp_y          = '0;
      found          = 1'b0;
      emit_go        = 1'b0;
      emit_id        = hold_id_ff;
      emit_tally     = hold_tally_ff;
      emit_status    = hold_status_ff;
      emit_last      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               func_in  = req_tuser;
               a_in     = req_tdata[5:0];
               b_in     = req_tdata[11:6];
               state_in = S_CHK;
            end
         end

         S_CHK: begin
            n_in        = '0;
            hold_vld_in = 1'b0;
            case (func_ff)
               FUNC_ADD, FUNC_MUTUAL: begin
                  if (!a_ok || !b_ok) begin
                     hold_vld_in    = 1'b1;
                     hold_id_in     = '0;
                     hold_tally_in  = '0;
                     hold_status_in = STAT_RANGE;
                     state_in       = S_FIN;
                  end else begin
                     state_in = (func_ff == FUNC_ADD) ? S_ADD_RD : S_MUT_LA;
                  end
               end
               FUNC_INFLUENT, FUNC_ACTIVE: begin
                  u_in       = 7'd1;
                  best_in    = '0;
                  best_id_in = '0;
                  state_in   = S_SCAN_RD;
               end
               FUNC_SUGGEST: begin
                  if (!a_ok) begin
                     hold_vld_in    = 1'b1;
                     hold_id_in     = '0;
                     hold_tally_in  = '0;
                     hold_status_in = STAT_RANGE;
                     state_in       = S_FIN;
                  end else begin
                     seen_in              = '0;
                     seen_in[a_ff[UW-1:0]] = 1'b1;
                     state_in             = S_SUG_LA;
                  end
               end
               default: begin
                  // unknown request: one empty item
                  state_in = S_FIN;
               end
            endcase
         end

         // add: fetch length of the followed user and activity of the follower
         S_ADD_RD: begin
            len_raddr = a_ff[UW-1:0];
            act_raddr = b_ff[UW-1:0];
            state_in  = S_ADD_WR;
         end

         S_ADD_WR: begin
            cmp_x          = 9'(MAX_DEGREE);
            cmp_y          = 9'(len_rd);
            hold_vld_in    = 1'b1;
            hold_id_in     = b_ff;
            if (!cmp_res.gt) begin
               hold_tally_in  = 9'(len_rd);
               hold_status_in = STAT_FULL;
            end else begin
               st_we      = 1'b1;
               st_waddr   = st_addr(a_ff, len_rd);
               st_wdata   = b_ff;
               len_we     = 1'b1;
               len_waddr  = a_ff[UW-1:0];
               len_wdata  = len_rd + 1'b1;
               len_vld_in[a_ff[UW-1:0]] = 1'b1;
               act_we     = 1'b1;
               act_waddr  = b_ff[UW-1:0];
               // activity saturates at all ones
               act_wdata  = (&act_rd) ? act_rd : act_rd + 1'b1;
               act_vld_in[b_ff[UW-1:0]] = 1'b1;
               hold_tally_in  = 9'(len_rd) + 9'd1;
               hold_status_in = STAT_OK;
            end
            state_in = S_FIN;
         end

         // most influential / most active: linear scan, strict greater keeps lowest id
         S_SCAN_RD: begin
            if (u_ff > live) begin
               hold_vld_in    = 1'b1;
               hold_id_in     = best_id_ff;
               hold_tally_in  = best_ff;
               hold_status_in = STAT_OK;
               state_in       = S_FIN;
            end else begin
               len_raddr = u_ff[UW-1:0];
               act_raddr = u_ff[UW-1:0];
               state_in  = S_SCAN_CMP;
            end
         end

         S_SCAN_CMP: begin
            cmp_x = (func_ff == FUNC_INFLUENT) ? 9'(len_rd) : act_rd;
            cmp_y = best_ff;
            if (cmp_res.gt) begin
               best_in    = cmp_x;
               best_id_in = u_ff[ID_W-1:0];
            end
            u_in     = u_ff + 7'd1;
            state_in = S_SCAN_RD;
         end

         // mutual: nested walk over both lists
         S_MUT_LA: begin
            len_raddr = a_ff[UW-1:0];
            state_in  = S_MUT_LB;
         end

         S_MUT_LB: begin
            len_a_in  = len_rd;
            len_raddr = b_ff[UW-1:0];
            state_in  = S_MUT_LBW;
         end

         S_MUT_LBW: begin
            len_b_in = len_rd;
            i_in     = '0;
            state_in = S_MUT_F1;
         end

         S_MUT_F1: begin
            if (i_ff == len_a_ff) begin
               state_in = S_FIN;
            end else begin
               st_raddr = st_addr(a_ff, i_ff);
               state_in = S_MUT_F1W;
            end
         end

         S_MUT_F1W: begin
            f1_in    = st_q;
            j_in     = '0;
            state_in = S_MUT_F2;
         end

         S_MUT_F2: begin
            if (j_ff == len_b_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_MUT_F1;
            end else begin
               st_raddr = st_addr(b_ff, j_ff);
               state_in = S_MUT_F2W;
            end
         end

         S_MUT_F2W: begin
            // keep the read address so a stalled match still sees its entry
            st_raddr = st_addr(b_ff, j_ff);
            cmp_x = 9'(f1_ff);
            cmp_y = 9'(st_q);
            found = cmp_res.eq;
            if (!found) begin
               j_in     = j_ff + 1'b1;
               state_in = S_MUT_F2;
            end else if (!hold_vld_ff || out_free) begin
               // previous match goes out, the new one waits for the next
               emit_go        = hold_vld_ff;
               hold_vld_in    = 1'b1;
               hold_id_in     = st_q;
               hold_tally_in  = '0;
               hold_status_in = STAT_OK;
               n_in           = n_ff + 1'b1;
               j_in           = j_ff + 1'b1;
               state_in       = (n_ff == 7'(RESULT_CAP - 1)) ? S_FIN : S_MUT_F2;
            end
         end

         // suggest: two-hop walk with a seen map
         S_SUG_LA: begin
            len_raddr = a_ff[UW-1:0];
            state_in  = S_SUG_LAW;
         end

         S_SUG_LAW: begin
            len_a_in = len_rd;
            i_in     = '0;
            state_in = S_SUG_MID;
         end

         S_SUG_MID: begin
            if (i_ff == len_a_ff) begin
               state_in = S_FIN;
            end else begin
               st_raddr = st_addr(a_ff, i_ff);
               state_in = S_SUG_MIDW;
            end
         end

         S_SUG_MIDW: begin
            cmp_x  = 9'(st_q);
            cmp_y  = 9'(LIVE_CAP);
            mid_in = st_q;
            if (cmp_res.gt) begin
               i_in     = i_ff + 1'b1;
               state_in = S_SUG_MID;
            end else begin
               len_raddr = st_q[UW-1:0];
               state_in  = S_SUG_LM;
            end
         end

         S_SUG_LM: begin
            len_b_in = len_rd;
            j_in     = '0;
            state_in = S_SUG_F;
         end

         S_SUG_F: begin
            if (j_ff == len_b_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_SUG_MID;
            end else begin
               st_raddr = st_addr(mid_ff, j_ff);
               state_in = S_SUG_FW;
            end
         end

         S_SUG_FW: begin
            // keep the read address so a stalled hit still sees its entry
            st_raddr = st_addr(mid_ff, j_ff);
            cmp_x = 9'(st_q);
            cmp_y = 9'(LIVE_CAP);
            found = !cmp_res.gt && !seen_ff[st_q[UW-1:0]];
            if (!found) begin
               j_in     = j_ff + 1'b1;
               state_in = S_SUG_F;
            end else if (!hold_vld_ff || out_free) begin
               emit_go                = hold_vld_ff;
               seen_in[st_q[UW-1:0]]  = 1'b1;
               hold_vld_in            = 1'b1;
               hold_id_in             = st_q;
               hold_tally_in          = '0;
               hold_status_in         = STAT_OK;
               n_in                   = n_ff + 1'b1;
               j_in                   = j_ff + 1'b1;
               state_in = (n_ff == 7'(RESULT_CAP - 1)) ? S_FIN : S_SUG_F;
            end
         end

         // final item carries last; nothing held means the empty answer
         S_FIN: begin
            if (out_free) begin
               emit_go     = 1'b1;
               emit_last   = 1'b1;
               if (!hold_vld_ff) begin
                  emit_id     = '0;
                  emit_tally  = '0;
                  emit_status = STAT_OK;
               end
               hold_vld_in = 1'b0;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         user_count_ff <= 6'd63;
         hold_vld_ff   <= 1'b0;
         len_vld_ff    <= '0;
         act_vld_ff    <= '0;
         n_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         hold_vld_ff <= hold_vld_in;
         len_vld_ff  <= len_vld_in;
         act_vld_ff  <= act_vld_in;
         n_ff        <= n_in;
         if (csr_valid) begin
            user_count_ff <= csr_data;
         end
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      func_ff        <= func_in;
      a_ff           <= a_in;
      b_ff           <= b_in;
      i_ff           <= i_in;
      j_ff           <= j_in;
      len_a_ff       <= len_a_in;
      len_b_ff       <= len_b_in;
      f1_ff          <= f1_in;
      mid_ff         <= mid_in;
      u_ff           <= u_in;
      best_ff        <= best_in;
      best_id_ff     <= best_id_in;
      hold_id_ff     <= hold_id_in;
      hold_tally_ff  <= hold_tally_in;
      hold_status_ff <= hold_status_in;
      seen_ff        <= seen_in;
      len_raddr_ff   <= len_raddr;
      act_raddr_ff   <= act_raddr;
      if (emit_go) begin
         rsp_data_ff <= {7'd0, emit_status, emit_tally, emit_id};
         rsp_last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   // sequencer is always in exactly one state
   a_state_onehot : assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   // nothing may be held between requests
   a_idle_empty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !hold_vld_ff)
      else $error("result held while idle");

   // result count never passes the cap
   a_cap : assert property (@(posedge clock) disable iff (reset)
      n_ff <= 7'(RESULT_CAP))
      else $error("result count beyond cap");

   // an out-of-range answer is always the only item of its request
   a_range_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[16:15] == STAT_RANGE)) |-> rsp_tlast)
      else $error("range error item without last");
`endif

endmodule

// ===== hdl/fgq_ram.sv =====
module fgq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/fgq_cmp.sv =====
module fgq_cmp (
   input  logic [8:0]          op_x,
   input  logic [8:0]          op_y,
   output fgq_pkg::cmp_res_type res
);
   import fgq_pkg::*;

   // single magnitude compare shared by every scan step
   always_comb begin
      res.gt = (op_x > op_y);
      res.eq = (op_x == op_y);
   end

endmodule

// ===== tb/sv/follower_graph_query_engine_core_tb.sv =====
module follower_graph_query_engine_core_tb;
   import fgq_pkg::*;

   localparam int MAX_USERS  = 63;
   localparam int MAX_DEGREE = 8;
   localparam int STALL_LIMIT = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [5:0]  csr_data = '0;

   typedef struct packed {
      logic [ID_W-1:0]     user_id;
      logic [TALLY_W-1:0]  tally;
      logic [STATUS_W-1:0] status;
      logic                last;
   } answer_type;

   typedef struct {
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   a;
      logic [ID_W-1:0]   b;
      bit                typed;   // expected answer written in the row
      answer_type        ans;
   } query_row_type;

   // graph shadow
   logic [ID_W-1:0]    shadow_store [0:MAX_USERS][0:MAX_DEGREE-1];
   int unsigned        shadow_len   [0:MAX_USERS];
   int unsigned        shadow_act   [0:MAX_USERS];
   int unsigned        shadow_users;
   answer_type         pending_answers [$];

   int  sender_idle_pct, receiver_stall_pct;
   bit  hold_receiver;
   bit  failed;
   int  quiet_cycles;

   follower_graph_query_engine_core DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit id_valid(input logic [ID_W-1:0] id);
      return id >= 1 && id <= shadow_users;
   endfunction

   function automatic answer_type mk(input int id, input int t, input logic [1:0] st);
      answer_type r;
      r.user_id = ID_W'(id); r.tally = TALLY_W'(t); r.status = st; r.last = 1'b0;
      return r;
   endfunction

   // work out the answers for one query and update the graph shadow
   task automatic predict_query(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] a,
                                input logic [ID_W-1:0] b);
      answer_type outq [$];
      bit seen [0:MAX_USERS];
      int best, best_id, v, f, m;
      bit capped;
      capped = 0;
      case (func)
         FUNC_ADD: begin
            if (!id_valid(a) || !id_valid(b)) outq = {outq, mk(0, 0, STAT_RANGE)};
            else if (shadow_len[a] >= MAX_DEGREE)
               outq = {outq, mk(int'(b), int'(shadow_len[a]), STAT_FULL)};
            else begin
               shadow_store[a][shadow_len[a]] = b;
               shadow_len[a]++;
               if (shadow_act[b] < 511) shadow_act[b]++;
               outq = {outq, mk(int'(b), int'(shadow_len[a]), STAT_OK)};
            end
         end
         FUNC_INFLUENT, FUNC_ACTIVE: begin
            best = 0; best_id = 0;
            for (int i = 1; i <= shadow_users; i++) begin
               v = (func == FUNC_INFLUENT) ? int'(shadow_len[i]) : int'(shadow_act[i]);
               if (v > best) begin best = v; best_id = i; end
            end
            outq = {outq, mk(best_id, best, STAT_OK)};
         end
         FUNC_MUTUAL: begin
            if (!id_valid(a) || !id_valid(b)) outq = {outq, mk(0, 0, STAT_RANGE)};
            else
               for (int i = 0; i < shadow_len[a] && !capped; i++)
                  for (int j = 0; j < shadow_len[b] && !capped; j++) begin
                     if (outq.size() >= RESULT_CAP) capped = 1;
                     else if (shadow_store[a][i] == shadow_store[b][j])
                        outq = {outq, mk(int'(shadow_store[a][i]), 0, STAT_OK)};
                  end
         end
         FUNC_SUGGEST: begin
            if (!id_valid(a)) outq = {outq, mk(0, 0, STAT_RANGE)};
            else begin
               foreach (seen[i]) seen[i] = 0;
               seen[a] = 1;
               for (int i = 0; i < shadow_len[a] && !capped; i++) begin
                  m = int'(shadow_store[a][i]);
                  for (int j = 0; j < shadow_len[m] && !capped; j++) begin
                     f = int'(shadow_store[m][j]);
                     if (!seen[f]) begin
                        if (outq.size() >= RESULT_CAP) capped = 1;
                        else begin seen[f] = 1; outq = {outq, mk(f, 0, STAT_OK)}; end
                     end
                  end
               end
            end
         end
         default: outq = {outq, mk(0, 0, STAT_OK)};   // unknown request kind
      endcase
      if (outq.size() == 0) outq = {outq, mk(0, 0, STAT_OK)};
      outq[outq.size()-1].last = 1'b1;
      foreach (outq[i]) pending_answers = {pending_answers, outq[i]};
   endtask

   // one request transfer; valid stays up afterwards until the next gap or rest
   task automatic send_query(input logic [FUNC_W-1:0] func, input logic [ID_W-1:0] a,
                             input logic [ID_W-1:0] b);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {4'b0, b, a};
      predict_query(func, a, b);
      do @(posedge clock); while (!req_tready);
   endtask

   // drop valid when no further request follows right away
   task automatic rest_sender();
      req_tvalid <= 1'b0;
   endtask

   // register write once the block is quiet
   task automatic write_user_count(input logic [5:0] value);
      rest_sender();
      wait (pending_answers.size() == 0);
      repeat (300) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      shadow_users = (value > MAX_USERS) ? MAX_USERS : value;
   endtask

   task automatic random_phase(input int count, input int idle, input int stall);
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0] a, b;
      int pick;
      sender_idle_pct = idle; receiver_stall_pct = stall;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         // mostly adds and queries inside a small id range so lists fill up
         if (pick < 45) func = FUNC_ADD;
         else if (pick < 53) func = FUNC_INFLUENT;
         else if (pick < 61) func = FUNC_ACTIVE;
         else if (pick < 76) func = FUNC_MUTUAL;
         else if (pick < 94) func = FUNC_SUGGEST;
         else func = FUNC_W'($urandom_range(7, 5));
         if ($urandom_range(9) == 0) begin
            a = ID_W'($urandom); b = ID_W'($urandom);   // noise, often out of range
         end else begin
            a = ID_W'($urandom_range(shadow_users < 12 ? shadow_users : 12, 1));
            b = ID_W'($urandom_range(shadow_users < 12 ? shadow_users : 12, 1));
         end
         send_query(func, a, b);
      end
   endtask

   // response checker against the oldest pending answer
   always @(posedge clock) begin
      answer_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.user_id = rsp_tdata[5:0];
         got.tally   = rsp_tdata[14:6];
         got.status  = rsp_tdata[16:15];
         got.last    = rsp_tlast;
         if (pending_answers.size() == 0) begin
            $error("unexpected response transfer user_id=%0d", got.user_id);
            failed = 1;
         end else begin
            want = pending_answers.pop_front();
            if (got.user_id !== want.user_id) begin
               $error("user_id expected %0d actual %0d", want.user_id, got.user_id); failed = 1;
            end
            if (got.tally !== want.tally) begin
               $error("tally expected %0d actual %0d", want.tally, got.tally); failed = 1;
            end
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status); failed = 1;
            end
            if (got.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, got.last); failed = 1;
            end
         end
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_receiver && ($urandom_range(99) >= receiver_stall_pct);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else
         quiet_cycles <= quiet_cycles + 1;
   end

   // directed rows; typed answers only where obvious
   query_row_type directed_rows [] = '{
      '{FUNC_INFLUENT, 6'd0,  6'd0,  1, '{6'd0, 9'd0, STAT_OK, 1'b1}},     // empty graph
      '{FUNC_ACTIVE,   6'd0,  6'd0,  1, '{6'd0, 9'd0, STAT_OK, 1'b1}},
      '{FUNC_ADD,      6'd0,  6'd5,  1, '{6'd0, 9'd0, STAT_RANGE, 1'b1}},  // id zero
      '{FUNC_ADD,      6'd5,  6'd63, 1, '{6'd63, 9'd1, STAT_OK, 1'b1}},    // top id
      '{FUNC_ADD,      6'd63, 6'd63, 1, '{6'd63, 9'd1, STAT_OK, 1'b1}},    // self follow
      '{FUNC_ADD,      6'd1,  6'd2,  1, '{6'd2, 9'd1, STAT_OK, 1'b1}},
      '{FUNC_ADD,      6'd2,  6'd3,  0, '{default:0}},
      '{FUNC_ADD,      6'd2,  6'd1,  0, '{default:0}},
      '{FUNC_ADD,      6'd3,  6'd2,  0, '{default:0}},
      '{FUNC_ADD,      6'd5,  6'd2,  0, '{default:0}},
      '{FUNC_MUTUAL,   6'd3,  6'd5,  0, '{default:0}},
      '{FUNC_MUTUAL,   6'd1,  6'd4,  1, '{6'd0, 9'd0, STAT_OK, 1'b1}},     // empty answer
      '{FUNC_MUTUAL,   6'd1,  6'd0,  1, '{6'd0, 9'd0, STAT_RANGE, 1'b1}},
      '{FUNC_SUGGEST,  6'd1,  6'd0,  0, '{default:0}},
      '{FUNC_SUGGEST,  6'd63, 6'd0,  0, '{default:0}},
      '{FUNC_SUGGEST,  6'd0,  6'd0,  1, '{6'd0, 9'd0, STAT_RANGE, 1'b1}},
      '{FUNC_INFLUENT, 6'd0,  6'd0,  0, '{default:0}},
      '{FUNC_ACTIVE,   6'd0,  6'd0,  0, '{default:0}},
      '{3'd5,          6'd63, 6'd63, 1, '{6'd0, 9'd0, STAT_OK, 1'b1}},     // unknown kinds
      '{3'd7,          6'd42, 6'd21, 1, '{6'd0, 9'd0, STAT_OK, 1'b1}}
   };

   initial begin
      foreach (shadow_len[i]) begin shadow_len[i] = 0; shadow_act[i] = 0; end
      shadow_users = MAX_USERS;
      failed = 0; hold_receiver = 0; quiet_cycles = 0;
      sender_idle_pct = 0; receiver_stall_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_query(directed_rows[i].func, directed_rows[i].a, directed_rows[i].b);
         if (directed_rows[i].typed) begin
            // the table value must agree with the shadow prediction
            if (pending_answers[pending_answers.size()-1] !== directed_rows[i].ans) begin
               $error("row %0d: typed answer differs from prediction", i);
               failed = 1;
            end
         end
      end
      // fill one list to the brim, then overflow it
      for (int k = 0; k < 9; k++) send_query(FUNC_ADD, 6'd4, 6'(k + 1));
      // dense mutual: 8x8 identical lists hit the result cap
      for (int k = 0; k < 8; k++) send_query(FUNC_ADD, 6'd6, 6'd7);
      for (int k = 0; k < 8; k++) send_query(FUNC_ADD, 6'd8, 6'd7);
      send_query(FUNC_MUTUAL, 6'd6, 6'd8);

      random_phase(100, 0, 0);
      write_user_count(6'd1);                       // lower extreme
      random_phase(20, 59, 0);
      write_user_count(6'd10);                      // stored ids beyond range stay
      random_phase(100, 59, 0);
      random_phase(80, 0, 59);
      write_user_count(6'd63);                      // upper extreme
      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_receiver = 1;
            repeat (400) @(posedge clock);
            hold_receiver = 0;
         end
         random_phase(40, 0, 0);
      join
      random_phase(40, 17, 17);
      rest_sender();

      wait (pending_answers.size() == 0);
      repeat (300) @(posedge clock);
      if (!failed && pending_answers.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
